// ----- sv/obdp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// obdp_pkg
// shared types and codes for the order book depth pricer
// ----------------------------------------------------------------------------
package obdp_pkg;

  localparam int unsigned PriceW  = 24;
  localparam int unsigned IdW     = 32;
  localparam int unsigned QtyW    = 20;
  localparam int unsigned StampW  = 32;
  localparam int unsigned TotalW  = 27;
  localparam int unsigned AmountW = 44;

  localparam logic [1:0] KIND_AMOUNT = 2'd0;
  localparam logic [1:0] KIND_NA     = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_REDUCE = 1'b1;
  localparam logic SIDE_BID  = 1'b0;
  localparam logic SIDE_ASK  = 1'b1;

  typedef struct packed {
    logic [PriceW-1:0] price;
    logic [IdW-1:0]    id;
    logic [QtyW-1:0]   rem;
  } entry_t;

  typedef struct packed {
    logic load;
    logic rd;
    logic rd_prev;
    logic ins_shift;
    logic ins_place;
    logic red_step;
    logic red_next;
    logic red_hit;
    logic pr_init;
    logic pr_mul;
    logic pr_acc;
    logic out_amt;
    logic out_na;
    logic out_err;
  } cmd_t;

  typedef struct packed {
    logic full_in;
    logic k_zero;
    logic k_end;
    logic behind;
    logic id_hit;
    logic side;
    logic at_target;
    logic reported;
    logic left_zero;
  } sts_t;

endpackage
`default_nettype wire

// ----- sv/obdp_dpath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// obdp_dpath
// book memory, side counters and totals, fill cost walk, result register
// ----------------------------------------------------------------------------
module obdp_dpath import obdp_pkg::*; #(
  parameter int unsigned ORDERS_PER_SIDE = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [QtyW-1:0]    cfg_wdata_i,
  input  wire logic               op_i,
  input  wire logic [IdW-1:0]     order_id_i,
  input  wire logic               side_i,
  input  wire logic [PriceW-1:0]  price_cents_i,
  input  wire logic [QtyW-1:0]    quantity_i,
  input  wire logic [StampW-1:0]  timestamp_i,
  input  wire cmd_t               cmd_i,
  output sts_t                    sts_o,
  output logic                    strobe_o,
  output logic [StampW-1:0]       stamp_out_o,
  output logic                    side_out_o,
  output logic [1:0]              report_kind_o,
  output logic [AmountW-1:0]      amount_cents_o
);

  localparam int unsigned IW = (ORDERS_PER_SIDE > 1) ? $clog2(ORDERS_PER_SIDE) : 1;
  localparam int unsigned CW = $clog2(ORDERS_PER_SIDE + 1);
  localparam int unsigned MD = 2 << IW;

  entry_t mem_q [MD];
  entry_t rdat_q;

  logic              op_q, side_q;
  logic [IdW-1:0]    id_q;
  logic [PriceW-1:0] price_q;
  logic [QtyW-1:0]   qty_q, tgt_q, left_q, left_d;
  logic [StampW-1:0] stamp_q;
  logic [CW-1:0]     k_q, k_d, k_m1;
  logic [CW-1:0]     cnt_q [2];
  logic [TotalW-1:0] tot_q [2];
  logic [1:0]        rep_q;
  logic [AmountW-1:0] prod_q, amt_q, amt_d;

  logic              we;
  logic [IW:0]       waddr, raddr;
  entry_t            wdata;
  logic [QtyW-1:0]   cut, take;

  logic              strobe_d;
  logic [1:0]        kind_d;
  logic              oside_d;

  assign k_m1 = k_q - CW'(1);
  assign cut  = (qty_q < rdat_q.rem) ? qty_q : rdat_q.rem;
  assign take = (rdat_q.rem > left_q) ? left_q : rdat_q.rem;

  always_comb begin
    raddr = {side_q, (cmd_i.rd_prev ? k_m1[IW-1:0] : k_q[IW-1:0])};
    waddr = {side_q, k_q[IW-1:0]};
    we    = 1'b0;
    wdata = rdat_q;
    if (cmd_i.ins_shift) begin
      we = 1'b1;
    end else if (cmd_i.ins_place) begin
      we    = 1'b1;
      wdata = '{price: price_q, id: id_q, rem: qty_q};
    end else if (cmd_i.red_hit) begin
      we        = 1'b1;
      wdata.rem = rdat_q.rem - cut;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (cmd_i.rd) begin
      rdat_q <= mem_q[raddr];
    end
  end

  always_comb begin
    k_d    = k_q;
    left_d = left_q;
    amt_d  = amt_q;
    if (cmd_i.load) begin
      k_d = (op_i == OP_ADD) ? cnt_q[side_i] : '0;
    end else if (cmd_i.ins_shift) begin
      k_d = k_m1;
    end else if (cmd_i.red_step || cmd_i.pr_mul) begin
      k_d = k_q + CW'(1);
    end else if (cmd_i.red_next || cmd_i.pr_init) begin
      k_d = '0;
    end
    if (cmd_i.pr_init) begin
      left_d = tgt_q;
      amt_d  = '0;
    end else if (cmd_i.pr_mul) begin
      left_d = left_q - take;
    end else if (cmd_i.pr_acc) begin
      amt_d = amt_q + prod_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= op_i;
      id_q    <= order_id_i;
      price_q <= price_cents_i;
      qty_q   <= quantity_i;
      stamp_q <= timestamp_i;
    end
    if (cmd_i.pr_mul) begin
      prod_q <= AmountW'(take) * AmountW'(rdat_q.price);
    end
    k_q    <= k_d;
    left_q <= left_d;
    amt_q  <= amt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_q  <= QtyW'(1);
      side_q <= SIDE_BID;
      cnt_q  <= '{default: '0};
      tot_q  <= '{default: '0};
      rep_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        tgt_q <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        side_q <= (op_i == OP_ADD) ? side_i : SIDE_BID;
      end else if (cmd_i.red_next) begin
        side_q <= SIDE_ASK;
      end
      if (cmd_i.ins_place) begin
        cnt_q[side_q] <= cnt_q[side_q] + CW'(1);
        tot_q[side_q] <= tot_q[side_q] + TotalW'(qty_q);
      end else if (cmd_i.red_hit) begin
        tot_q[side_q] <= tot_q[side_q] - TotalW'(cut);
      end
      if (cmd_i.out_amt) begin
        rep_q[side_q] <= 1'b1;
      end else if (cmd_i.out_na) begin
        rep_q[side_q] <= 1'b0;
      end
    end
  end

  // result register
  always_comb begin
    strobe_d = cmd_i.out_amt | cmd_i.out_na | cmd_i.out_err;
    kind_d   = KIND_ERROR;
    oside_d  = side_q;
    if (cmd_i.out_amt) begin
      kind_d = KIND_AMOUNT;
    end else if (cmd_i.out_na) begin
      kind_d = KIND_NA;
    end else if (op_q == OP_REDUCE) begin
      oside_d = SIDE_BID;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_o <= 1'b0;
    end else begin
      strobe_o <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (strobe_d) begin
      stamp_out_o    <= stamp_q;
      side_out_o     <= oside_d;
      report_kind_o  <= kind_d;
      amount_cents_o <= cmd_i.out_amt ? amt_q : '0;
    end
  end

  always_comb begin
    sts_o.full_in   = (cnt_q[side_i] == CW'(ORDERS_PER_SIDE));
    sts_o.k_zero    = (k_q == '0);
    sts_o.k_end     = (k_q == cnt_q[side_q]);
    sts_o.behind    = (side_q == SIDE_BID) ? (rdat_q.price <= price_q)
                                           : (rdat_q.price >= price_q);
    sts_o.id_hit    = (rdat_q.id == id_q);
    sts_o.side      = side_q;
    sts_o.at_target = (tot_q[side_q] >= TotalW'(tgt_q));
    sts_o.reported  = rep_q[side_q];
    sts_o.left_zero = (left_q == '0);
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q[0] <= CW'(ORDERS_PER_SIDE)) && (cnt_q[1] <= CW'(ORDERS_PER_SIDE)))
    else $error("side count above capacity");
  a_kind_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> (report_kind_o == KIND_AMOUNT || report_kind_o == KIND_NA ||
                  report_kind_o == KIND_ERROR))
    else $error("bad report kind");
  a_amt_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && report_kind_o != KIND_AMOUNT) |-> (amount_cents_o == '0))
    else $error("amount on non-amount result");
  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_i.ins_shift, cmd_i.ins_place, cmd_i.red_hit}))
    else $error("conflicting book writes");

endmodule
`default_nettype wire

// ----- sv/obdp_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// obdp_ctrl
// sequencer for insert, reduce search and fill cost walk
// ----------------------------------------------------------------------------
module obdp_ctrl import obdp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  input  wire logic op_i,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o,
  output logic      busy
);

  typedef enum logic [10:0] {
    S_IDLE    = 11'b000_0000_0001,
    S_INS_RD  = 11'b000_0000_0010,
    S_INS_CHK = 11'b000_0000_0100,
    S_RED_RD  = 11'b000_0000_1000,
    S_RED_CHK = 11'b000_0001_0000,
    S_PRICE   = 11'b000_0010_0000,
    S_PR_RD   = 11'b000_0100_0000,
    S_PR_MUL  = 11'b000_1000_0000,
    S_PR_ACC  = 11'b001_0000_0000,
    S_PR_OUT  = 11'b010_0000_0000,
    S_ERR     = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  assign busy = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          if (op_i == OP_ADD) begin
            state_d = sts_i.full_in ? S_ERR : S_INS_RD;
          end else begin
            state_d = S_RED_RD;
          end
        end
      end
      S_INS_RD: begin
        if (sts_i.k_zero) begin
          cmd_o.ins_place = 1'b1;
          state_d = S_PRICE;
        end else begin
          cmd_o.rd      = 1'b1;
          cmd_o.rd_prev = 1'b1;
          state_d = S_INS_CHK;
        end
      end
      S_INS_CHK: begin
        if (sts_i.behind) begin
          cmd_o.ins_shift = 1'b1;
          state_d = S_INS_RD;
        end else begin
          cmd_o.ins_place = 1'b1;
          state_d = S_PRICE;
        end
      end
      S_RED_RD: begin
        if (sts_i.k_end) begin
          if (sts_i.side == SIDE_BID) begin
            cmd_o.red_next = 1'b1;
          end else begin
            state_d = S_ERR;
          end
        end else begin
          cmd_o.rd = 1'b1;
          state_d = S_RED_CHK;
        end
      end
      S_RED_CHK: begin
        if (sts_i.id_hit) begin
          cmd_o.red_hit = 1'b1;
          state_d = S_PRICE;
        end else begin
          cmd_o.red_step = 1'b1;
          state_d = S_RED_RD;
        end
      end
      S_PRICE: begin
        if (sts_i.at_target) begin
          cmd_o.pr_init = 1'b1;
          state_d = S_PR_RD;
        end else begin
          cmd_o.out_na = sts_i.reported;
          state_d = S_IDLE;
        end
      end
      S_PR_RD: begin
        if (sts_i.k_end || sts_i.left_zero) begin
          state_d = S_PR_OUT;
        end else begin
          cmd_o.rd = 1'b1;
          state_d = S_PR_MUL;
        end
      end
      S_PR_MUL: begin
        cmd_o.pr_mul = 1'b1;
        state_d = S_PR_ACC;
      end
      S_PR_ACC: begin
        cmd_o.pr_acc = 1'b1;
        state_d = S_PR_RD;
      end
      S_PR_OUT: begin
        cmd_o.out_amt = 1'b1;
        state_d = S_IDLE;
      end
      S_ERR: begin
        cmd_o.out_err = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q != S_IDLE))
    else $error("accepted request left idle");
  a_emit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.out_amt || cmd_o.out_err) |=> (state_q == S_IDLE))
    else $error("result not followed by idle");

endmodule
`default_nettype wire

// ----- sv/order_book_depth_pricer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// order_book_depth_pricer
// two-sided bounded order book that prices a target quantity
// ----------------------------------------------------------------------------
// add: entries behind the new order are moved up one by one, then it is placed;
// reduce: entries are searched by id, bid side first and then the ask side;
// pricing then walks the entries, one book memory read per step
// throughput: one request at a time, a new one is taken only while busy is low
// the result strobe is high for one cycle and cannot be stalled
// reset clears counts, totals, report flags and sets target to 1; no clear pass
module order_book_depth_pricer import obdp_pkg::*; #(
  parameter int unsigned ORDERS_PER_SIDE = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [QtyW-1:0]    cfg_wdata_i,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               op_i,
  input  wire logic [IdW-1:0]     order_id_i,
  input  wire logic               side_i,
  input  wire logic [PriceW-1:0]  price_cents_i,
  input  wire logic [QtyW-1:0]    quantity_i,
  input  wire logic [StampW-1:0]  timestamp_i,
  output logic                    strobe_o,
  output logic [StampW-1:0]       stamp_out_o,
  output logic                    side_out_o,
  output logic [1:0]              report_kind_o,
  output logic [AmountW-1:0]      amount_cents_o
);

  cmd_t cmd;
  sts_t sts;

  obdp_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .op_i   (op_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  obdp_dpath #(
    .ORDERS_PER_SIDE (ORDERS_PER_SIDE)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .op_i           (op_i),
    .order_id_i     (order_id_i),
    .side_i         (side_i),
    .price_cents_i  (price_cents_i),
    .quantity_i     (quantity_i),
    .timestamp_i    (timestamp_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .strobe_o       (strobe_o),
    .stamp_out_o    (stamp_out_o),
    .side_out_o     (side_out_o),
    .report_kind_o  (report_kind_o),
    .amount_cents_o (amount_cents_o)
  );

endmodule
`default_nettype wire
